// ----- hw/rtl/tddr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tddr_pkg
// Shared types and constants of the table-driven dfa recognizer: request
// opcodes, register reset values, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tddr_pkg;

  // request opcodes
  localparam logic [1:0] CMD_WR_SYM  = 2'd0;
  localparam logic [1:0] CMD_WR_TBL  = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_FEED    = 2'd3;

  // configuration register indexes and reset values
  localparam logic REG_NUM_STATES  = 1'b0;
  localparam logic REG_NUM_SYMBOLS = 1'b1;
  localparam logic [4:0] RST_NUM_STATES  = 5'd16;
  localparam logic [4:0] RST_NUM_SYMBOLS = 5'd16;
  localparam logic [4:0] MIN_NUM_STATES  = 5'd2;
  localparam logic [4:0] MIN_NUM_SYMBOLS = 5'd1;

  // controller states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_UPDATE
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic wr_sym;
    logic wr_tbl;
    logic restart;
    logic feed;
    logic update;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_valid;
    logic out_blocked;
  } dp_sts_t;

endpackage

// ----- hw/rtl/tddr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tddr_ctrl
// Request sequencer: decodes accepted requests into datapath commands and
// holds the update step of a feed until the result register is free.
// ----------------------------------------------------------------------------
module tddr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_cmd,
  output logic                in_stall,
  input  tddr_pkg::dp_sts_t   sts,
  output tddr_pkg::ctrl_cmd_t cmd
);

  tddr_pkg::ctrl_state_t state_r;
  tddr_pkg::ctrl_state_t state_nxt;
  logic                  accept;

  // requests are taken only while idle
  assign in_stall = (state_r != tddr_pkg::ST_IDLE);
  assign accept   = in_valid && (state_r == tddr_pkg::ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tddr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tddr_pkg::ST_IDLE: begin
        if (accept && (in_cmd == tddr_pkg::CMD_FEED)) begin
          state_nxt = tddr_pkg::ST_UPDATE;
        end
      end
      tddr_pkg::ST_UPDATE: begin
        if (!sts.out_blocked) begin
          state_nxt = tddr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tddr_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    unique case (state_r)
      tddr_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            tddr_pkg::CMD_WR_SYM:  cmd.wr_sym  = 1'b1;
            tddr_pkg::CMD_WR_TBL:  cmd.wr_tbl  = 1'b1;
            tddr_pkg::CMD_RESTART: cmd.restart = 1'b1;
            tddr_pkg::CMD_FEED:    cmd.feed    = 1'b1;
            default:               cmd.feed    = 1'b0;
          endcase
        end
      end
      tddr_pkg::ST_UPDATE: begin
        cmd.update = !sts.out_blocked;
      end
      default: cmd = '0;
    endcase
  end

  // a feed always leads into the update cycle
  a_feed_to_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.feed |=> (state_r == tddr_pkg::ST_UPDATE))
    else $error("feed did not enter update");

  // update returns to idle
  a_update_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> (state_r == tddr_pkg::ST_IDLE))
    else $error("update did not return to idle");

  // a waiting result holds the pending feed back
  a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == tddr_pkg::ST_UPDATE) && sts.out_valid && sts.out_blocked)
      |=> (state_r == tddr_pkg::ST_UPDATE))
    else $error("pending feed overran a waiting result");

endmodule

// ----- hw/rtl/tddr_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tddr_dpath
// Recognizer datapath: configuration registers, alphabet slots with a
// lowest-slot match, the next-state table memory, the current state and the
// result register.
// ----------------------------------------------------------------------------
module tddr_dpath #(
  parameter int MAX_STATES  = 16,
  parameter int MAX_SYMBOLS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  // request fields
  input  logic [3:0]          in_row,
  input  logic [3:0]          in_column,
  input  logic [7:0]          in_payload,
  // result
  output logic                out_valid,
  input  logic                out_stall,
  output logic [3:0]          out_state_now,
  output logic                out_accepted,
  output logic                out_symbol_known,
  // control
  input  tddr_pkg::ctrl_cmd_t cmd,
  output tddr_pkg::dp_sts_t   sts
);

  localparam int SYM_AW    = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int TBL_DEPTH = MAX_STATES * MAX_SYMBOLS;
  localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

  logic [4:0]        num_states_r;
  logic [4:0]        num_symbols_r;
  logic [4:0]        cfg_val;
  logic [4:0]        num_states_nxt;
  logic [4:0]        num_symbols_nxt;
  logic              cfg_wr;

  logic [7:0]        sym_r [MAX_SYMBOLS];
  logic              hit;
  logic [SYM_AW-1:0] slot;

  logic [3:0]        tbl_mem [TBL_DEPTH];
  logic [3:0]        tbl_rd_r;
  logic              wr_ok;
  logic [TBL_AW-1:0] wr_addr;
  logic              st_in_range;
  logic [TBL_AW-1:0] rd_addr;

  logic              hit_r;
  logic              move_r;
  logic [3:0]        cur_state_r;
  logic [3:0]        state_nxt;
  logic              acc_nxt;

  logic              out_valid_r;
  logic [3:0]        out_state_r;
  logic              out_acc_r;
  logic              out_known_r;

  // configuration write with saturation
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_val = pwdata[4:0];

  always_comb begin
    num_states_nxt = cfg_val;
    if (cfg_val < tddr_pkg::MIN_NUM_STATES) begin
      num_states_nxt = tddr_pkg::MIN_NUM_STATES;
    end else if (32'(cfg_val) > MAX_STATES) begin
      num_states_nxt = 5'(MAX_STATES);
    end
    num_symbols_nxt = cfg_val;
    if (cfg_val < tddr_pkg::MIN_NUM_SYMBOLS) begin
      num_symbols_nxt = tddr_pkg::MIN_NUM_SYMBOLS;
    end else if (32'(cfg_val) > MAX_SYMBOLS) begin
      num_symbols_nxt = 5'(MAX_SYMBOLS);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_states_r  <= tddr_pkg::RST_NUM_STATES;
      num_symbols_r <= tddr_pkg::RST_NUM_SYMBOLS;
    end else if (cfg_wr) begin
      if (paddr[2] == tddr_pkg::REG_NUM_STATES) begin
        num_states_r <= num_states_nxt;
      end else begin
        num_symbols_r <= num_symbols_nxt;
      end
    end
  end

  // register readback
  assign prdata = (paddr[2] == tddr_pkg::REG_NUM_SYMBOLS) ? 32'(num_symbols_r)
                                                           : 32'(num_states_r);

  // alphabet slots
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_SYMBOLS; j++) begin
      if (cmd.wr_sym && (32'(in_row) == j)) begin
        sym_r[j] <= in_payload;
      end
    end
  end

  // lowest matching slot among those in use
  always_comb begin
    hit  = 1'b0;
    slot = '0;
    for (int j = MAX_SYMBOLS - 1; j >= 0; j--) begin
      if ((j < int'(num_symbols_r)) && (sym_r[j] == in_payload)) begin
        hit  = 1'b1;
        slot = SYM_AW'(j);
      end
    end
  end

  // table addresses
  assign wr_ok       = (32'(in_row) < MAX_STATES) && (32'(in_column) < MAX_SYMBOLS);
  assign wr_addr     = TBL_AW'(32'(in_row) * MAX_SYMBOLS + 32'(in_column));
  assign st_in_range = (32'(cur_state_r) < MAX_STATES);
  assign rd_addr     = TBL_AW'(32'(cur_state_r) * MAX_SYMBOLS + 32'(slot));

  // next-state table memory
  always_ff @(posedge clk) begin
    if (cmd.wr_tbl && wr_ok) begin
      tbl_mem[wr_addr] <= in_payload[3:0];
    end
    if (cmd.feed) begin
      tbl_rd_r <= tbl_mem[rd_addr];
    end
  end

  // match flags for the update cycle
  always_ff @(posedge clk) begin
    if (cmd.feed) begin
      hit_r  <= hit;
      move_r <= hit && st_in_range;
    end
  end

  // new state and acceptance
  assign state_nxt = move_r ? tbl_rd_r : cur_state_r;
  assign acc_nxt   = (5'(state_nxt) == (num_states_r - 5'd1)) ||
                     (5'(state_nxt) == (num_states_r - 5'd2));

  // current state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_state_r <= '0;
    end else if (cmd.restart) begin
      cur_state_r <= '0;
    end else if (cmd.update) begin
      cur_state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.update) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_state_r <= state_nxt;
      out_acc_r   <= acc_nxt;
      out_known_r <= hit_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_state_now    = out_state_r;
  assign out_accepted     = out_acc_r;
  assign out_symbol_known = out_known_r;

  assign sts.out_valid   = out_valid_r;
  assign sts.out_blocked = out_valid_r && out_stall;

  // an update always presents a result
  a_update_presents: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> (out_valid_r && (out_state_r == cur_state_r)))
    else $error("update did not present the new state");

  // saturation keeps the state count usable
  a_num_states_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (num_states_r >= tddr_pkg::MIN_NUM_STATES) && (num_symbols_r != 5'd0))
    else $error("configuration register left its range");

  // a stalled result stays put
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_state_r)))
    else $error("stalled result changed");

endmodule

// ----- hw/rtl/table_driven_dfa_recognizer.sv -----
`timescale 1ns / 1ps
// a feed request's result is registered in the update state after acceptance,
//   following the registered read of the next-state table memory, once no stalled
//   result waits; the request channel stalls until then, so feeds do not overlap
// slot writes, table writes and restarts give no result and leave the channel idle
// reset: current state 0, num_states and num_symbols 16; slots and table keep
//   their contents and are not cleared
// ----------------------------------------------------------------------------
// table_driven_dfa_recognizer
// Programmable deterministic finite automaton with a loadable alphabet and
// next-state table; every fed byte reports the state, acceptance and match.
// ----------------------------------------------------------------------------
module table_driven_dfa_recognizer #(
  parameter int MAX_STATES  = 16,
  parameter int MAX_SYMBOLS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [3:0]  in_row,
  input  logic [3:0]  in_column,
  input  logic [7:0]  in_payload,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_state_now,
  output logic        out_accepted,
  output logic        out_symbol_known
);

  tddr_pkg::ctrl_cmd_t cmd;
  tddr_pkg::dp_sts_t   sts;

  // register access never waits: pready is held high
  assign pready = 1'b1;

  // sequencer
  tddr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  tddr_dpath #(
    .MAX_STATES  (MAX_STATES),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .in_row           (in_row),
    .in_column        (in_column),
    .in_payload       (in_payload),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_state_now    (out_state_now),
    .out_accepted     (out_accepted),
    .out_symbol_known (out_symbol_known),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule
